[hw/rtl/hyst_pkg.sv]
// Package: phases, controller commands and status for hysteresis edge tracking.
package hyst_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_ISSUE,
        ST_NB_CHECK,
        ST_READ,
        ST_READ_WAIT,
        ST_OUT
    } t_state;

    localparam logic [1:0] REG_TLOW  = 2'd0;
    localparam logic [1:0] REG_THIGH = 2'd1;
    localparam logic [1:0] REG_ROWS  = 2'd2;
    localparam logic [1:0] REG_COLS  = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic frame_start;   // latch frame size
        logic load_write;    // write loaded pixel
        logic pop_issue;     // read stack top
        logic pop_take;      // capture popped position
        logic nb_issue;      // read neighbour memories
        logic nb_check;      // evaluate neighbour, maybe mark and push
        logic nb_next;       // advance neighbour index
        logic read_issue;    // read edge map at counter
        logic read_take;     // capture result
        logic read_done;     // result transferred, advance counter
    } t_cmd;

    typedef struct packed {
        logic load_last;     // current load is last pixel
        logic stack_empty;
        logic nb_last;       // neighbour index is the eighth
        logic read_last;     // current read is last pixel
    } t_status;

endpackage

[hw/rtl/hyst_ctrl.sv]
// Controller state machine for hysteresis edge tracking.
module hyst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_opcode,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_out_ready,
    input  hyst_pkg::t_status i_status,
    output hyst_pkg::t_cmd    o_cmd
);
    import hyst_pkg::*;

    t_state r_state, n_state;
    logic   r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state = r_state;
        n_first = r_first;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_ready = 1'b1;
                if (i_valid && i_opcode == OP_LOAD) begin
                    o_cmd.frame_start = r_first;
                    o_cmd.load_write  = 1'b1;
                    n_first = 1'b0;
                    if (i_status.load_last) begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (i_status.stack_empty) begin
                    n_state = ST_READ;
                end else begin
                    o_cmd.pop_issue = 1'b1;
                    n_state = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                o_cmd.pop_take = 1'b1;
                n_state = ST_NB_ISSUE;
            end
            ST_NB_ISSUE: begin
                o_cmd.nb_issue = 1'b1;
                n_state = ST_NB_CHECK;
            end
            ST_NB_CHECK: begin
                o_cmd.nb_check = 1'b1;
                o_cmd.nb_next  = 1'b1;
                n_state = i_status.nb_last ? ST_POP : ST_NB_ISSUE;
            end
            ST_READ: begin
                o_ready = 1'b1;
                if (i_valid && i_opcode == OP_READ) begin
                    o_cmd.read_issue = 1'b1;
                    n_state = ST_READ_WAIT;
                end
            end
            ST_READ_WAIT: begin
                o_cmd.read_take = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.read_done = 1'b1;
                    if (i_status.read_last) begin
                        n_state = ST_LOAD;
                        n_first = 1'b1;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end
endmodule

[hw/rtl/hyst_dp.sv]
// Datapath: pixel memories, position stack, neighbour generation, counters.
module hyst_dp #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hyst_pkg::t_cmd    i_cmd,
    output hyst_pkg::t_status o_status,
    input  logic [15:0]       i_pixel_value,
    input  logic [15:0]       i_tlow,
    input  logic [15:0]       i_thigh,
    input  logic [8:0]        i_rows,
    input  logic [8:0]        i_cols,
    output logic              o_edge_bit,
    output logic              o_last_pixel
);
    import hyst_pkg::*;

    localparam int RW = (MAX_ROWS > 256) ? $clog2(MAX_ROWS) + 1 : 9;
    localparam int CW = (MAX_COLUMNS > 256) ? $clog2(MAX_COLUMNS) + 1 : 9;
    localparam int NPIX = MAX_ROWS * MAX_COLUMNS;
    localparam int AW = $clog2(NPIX);
    localparam int DW = AW + 1;
    localparam int PW = RW + CW;

    logic [15:0] mem_mag  [NPIX];
    logic        mem_edge [NPIX];

    logic [RW-1:0] r_urows;
    logic [CW-1:0] r_ucols;
    logic [DW-1:0] r_sp;
    logic [RW-1:0] r_row, r_prow;
    logic [CW-1:0] r_col, r_pcol;
    logic [AW-1:0] r_addr;
    logic [2:0]    r_nb;
    logic [15:0]   r_mag_q;
    logic          r_edge_q;
    logic          r_nb_ok;
    logic [AW-1:0] r_nb_addr;
    logic          r_edge_out, r_last_out;

    logic [RW-1:0] cur_rows;
    logic [CW-1:0] cur_cols;
    logic [RW:0]   w_rows_sat;
    logic [CW:0]   w_cols_sat;

    always_comb begin
        w_rows_sat = (i_rows == 9'd0) ? (RW+1)'(1) :
                     ((RW+1)'(i_rows) > (RW+1)'(MAX_ROWS)) ? (RW+1)'(MAX_ROWS)
                                                           : (RW+1)'(i_rows);
        w_cols_sat = (i_cols == 9'd0) ? (CW+1)'(1) :
                     ((CW+1)'(i_cols) > (CW+1)'(MAX_COLUMNS)) ? (CW+1)'(MAX_COLUMNS)
                                                              : (CW+1)'(i_cols);
        cur_rows = i_cmd.frame_start ? w_rows_sat[RW-1:0] : r_urows;
        cur_cols = i_cmd.frame_start ? w_cols_sat[CW-1:0] : r_ucols;
    end

    // neighbour offsets
    logic signed [RW+1:0] nr;
    logic signed [CW+1:0] nc;
    logic [1:0] dr, dc;
    always_comb begin
        case (r_nb)
            3'd0: begin dr = 2'b11; dc = 2'b11; end
            3'd1: begin dr = 2'b11; dc = 2'b00; end
            3'd2: begin dr = 2'b11; dc = 2'b01; end
            3'd3: begin dr = 2'b00; dc = 2'b11; end
            3'd4: begin dr = 2'b00; dc = 2'b01; end
            3'd5: begin dr = 2'b01; dc = 2'b11; end
            3'd6: begin dr = 2'b01; dc = 2'b00; end
            default: begin dr = 2'b01; dc = 2'b01; end
        endcase
        nr = $signed({2'b00, r_prow}) + (RW+2)'($signed(dr));
        nc = $signed({2'b00, r_pcol}) + (CW+2)'($signed(dc));
    end
    logic w_nb_in;
    assign w_nb_in = !nr[RW+1] && !nc[CW+1] &&
                     (nr[RW:0] < {1'b0, r_urows}) && (nc[CW:0] < {1'b0, r_ucols});

    // position counter: raster address plus row/column
    logic w_col_wrap;
    assign w_col_wrap = (r_col == cur_cols - CW'(1));
    assign o_status.load_last   = w_col_wrap && (r_row == cur_rows - RW'(1));
    assign o_status.read_last   = (r_col == r_ucols - CW'(1)) &&
                                  (r_row == r_urows - RW'(1));
    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.nb_last     = (r_nb == 3'd7);

    logic w_adv;
    assign w_adv = i_cmd.load_write || i_cmd.read_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_urows <= RW'(MAX_ROWS < 256 ? MAX_ROWS : 256);
            r_ucols <= CW'(MAX_COLUMNS < 256 ? MAX_COLUMNS : 256);
            r_sp    <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_addr  <= '0;
            r_nb    <= '0;
        end else begin
            if (i_cmd.frame_start) begin
                r_urows <= cur_rows;
                r_ucols <= cur_cols;
            end
            if (w_adv) begin
                if (o_status.load_last || (i_cmd.read_done && o_status.read_last)) begin
                    r_row <= '0; r_col <= '0; r_addr <= '0;
                end else if (i_cmd.load_write ? w_col_wrap
                                              : (r_col == r_ucols - CW'(1))) begin
                    r_col <= '0; r_row <= r_row + RW'(1); r_addr <= r_addr + AW'(1);
                end else begin
                    r_col <= r_col + CW'(1); r_addr <= r_addr + AW'(1);
                end
            end
            if (i_cmd.load_write && (i_pixel_value >= i_thigh)) begin
                r_sp <= r_sp + DW'(1);
            end else if (i_cmd.pop_issue) begin
                r_sp <= r_sp - DW'(1);
            end else if (i_cmd.nb_check && r_nb_ok && (r_mag_q >= i_tlow) && !r_edge_q) begin
                r_sp <= r_sp + DW'(1);
            end
            if (i_cmd.read_done && o_status.read_last) r_sp <= '0;
            if (i_cmd.pop_take) r_nb <= '0;
            else if (i_cmd.nb_next) r_nb <= r_nb + 3'd1;
        end
    end

    // stack entries hold row/column packed, so a pop needs no division
    logic [PW-1:0] mem_rc [NPIX];
    logic [PW-1:0] r_rc_q;
    logic [PW-1:0] w_push_rc;
    logic          w_push;
    logic [AW-1:0] w_sp_a;
    assign w_sp_a = r_sp[AW-1:0];

    always_comb begin
        w_push    = 1'b0;
        w_push_rc = {r_row, r_col};
        if (i_cmd.load_write && (i_pixel_value >= i_thigh)) begin
            w_push = 1'b1;
        end else if (i_cmd.nb_check && r_nb_ok && (r_mag_q >= i_tlow) && !r_edge_q) begin
            w_push    = 1'b1;
            w_push_rc = {nr[RW-1:0], nc[CW-1:0]};
        end
    end

    // multiply for neighbour address: row * cols + col
    logic [AW-1:0] w_nb_addr;
    assign w_nb_addr = AW'(nr[RW-1:0]) * AW'(r_ucols) + AW'(nc[CW-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            mem_rc[w_sp_a] <= w_push_rc;
        end
        if (i_cmd.pop_issue) begin
            r_rc_q <= mem_rc[AW'(r_sp - DW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_take) begin
            r_prow <= r_rc_q[PW-1:CW];
            r_pcol <= r_rc_q[CW-1:0];
        end
        if (i_cmd.nb_issue) begin
            r_nb_ok   <= w_nb_in;
            r_nb_addr <= w_nb_addr;
        end
    end

    // magnitude memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) mem_mag[r_addr] <= i_pixel_value;
        if (i_cmd.nb_issue)   r_mag_q <= mem_mag[w_nb_addr];
    end

    // edge map
    logic [AW-1:0] w_erd;
    assign w_erd = i_cmd.nb_issue ? w_nb_addr : r_addr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            mem_edge[r_addr] <= (i_pixel_value >= i_thigh);
        end else if (i_cmd.nb_check && r_nb_ok && (r_mag_q >= i_tlow) && !r_edge_q) begin
            mem_edge[r_nb_addr] <= 1'b1;
        end
        if (i_cmd.nb_issue || i_cmd.read_issue) r_edge_q <= mem_edge[w_erd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_take) begin
            r_edge_out <= r_edge_q;
            r_last_out <= o_status.read_last;
        end
    end
    assign o_edge_bit   = r_edge_out;
    assign o_last_pixel = r_last_out;
endmodule

[hw/rtl/hysteresis_edge_tracking_unit.sv]
// Hysteresis edge tracking unit: top level with APB register file.
// Loads are taken at one pixel per cycle. Tracking pops a marked pixel from the
// stack (issue, then take), then checks each of its eight neighbours in turn
// (issue, then check) against the pixel memories.
// Reads pass through a memory read, the output register and the transfer.
// A read during loading is taken and dropped with no result; while the frame
// is being tracked the input is held off.
module hysteresis_edge_tracking_unit #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_pixel_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_edge_bit,
    output logic        o_last_pixel
);
    import hyst_pkg::*;

    logic [15:0] r_tlow, r_thigh;
    logic [8:0]  r_rows, r_cols;
    logic [1:0]  w_idx;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlow  <= '0;
            r_thigh <= '0;
            r_rows  <= 9'd256;
            r_cols  <= 9'd256;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_TLOW:  r_tlow  <= pwdata[15:0];
                REG_THIGH: r_thigh <= pwdata[15:0];
                REG_ROWS:  r_rows  <= pwdata[8:0];
                REG_COLS:  r_cols  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TLOW:  prdata = {16'd0, r_tlow};
            REG_THIGH: prdata = {16'd0, r_thigh};
            REG_ROWS:  prdata = {23'd0, r_rows};
            default:   prdata = {23'd0, r_cols};
        endcase
    end

    t_cmd    w_cmd;
    t_status w_status;

    hyst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_opcode   (i_opcode),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_out_ready(i_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    hyst_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_pixel_value(i_pixel_value),
        .i_tlow       (r_tlow),
        .i_thigh      (r_thigh),
        .i_rows       (r_rows),
        .i_cols       (r_cols),
        .o_edge_bit   (o_edge_bit),
        .o_last_pixel (o_last_pixel)
    );
endmodule

[hw/rtl/hyst_checker.sv]
// Port-level checker for the hysteresis edge tracking unit.
module hyst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_edge_bit,
    input logic o_last_pixel,
    input logic pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_edge_bit) && $stable(o_last_pixel))
        else $error("result dropped while stalled");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while result pending");
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("back-to-back results");
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind hysteresis_edge_tracking_unit hyst_checker u_hyst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_edge_bit(o_edge_bit),
    .o_last_pixel(o_last_pixel), .pready(pready)
);
